// File: design/acdm_pkg.sv
// Shared constants, codes and types for the adaptive color distance mask.
// No dependencies; every other file of the block but acdm_ram imports this package.
`default_nettype none

package acdm_pkg;

  localparam int MAX_PIXELS_LOG2 = 20;
  localparam int DISTANCE_BINS   = 444;

  localparam int CHAN_W    = 8;
  localparam int COUNT_W   = MAX_PIXELS_LOG2 + 1;
  localparam int SUM_W     = MAX_PIXELS_LOG2 + CHAN_W;
  localparam int CUT_W     = 9;
  localparam int BIN_AW    = $clog2(DISTANCE_BINS);
  localparam int RATIO_W   = 16;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = (COUNT_W > RATIO_W) ? COUNT_W : RATIO_W;
  localparam int SQ_W      = 2 * CHAN_W + 2;
  localparam int QSTEP_W   = $clog2(CHAN_W);
  localparam int LHS_W     = CUT_W + 1 + RATIO_W;
  localparam int RHS_W     = CUT_W + 1 + 8;

  localparam logic [COUNT_W-1:0] PIX_LIMIT = {1'b1, {MAX_PIXELS_LOG2{1'b0}}};
  localparam logic [CUT_W-1:0]   MAX_DIST_RESET = 9'd444;
  localparam logic [RATIO_W-1:0] RATIO_RESET    = 16'd256;

  // operation codes
  localparam logic [1:0] OP_ACCUMULATE = 2'd0;
  localparam logic [1:0] OP_FINISH     = 2'd1;
  localparam logic [1:0] OP_CLASSIFY   = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_TARGET_RED      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_GREEN    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_BLUE     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MIN_PIXELS      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DISTANCE    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PRECISION_RATIO = 3'd5;

  // result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_MASK   = 1'b1;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [CUT_W-1:0]   cut_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  typedef struct packed {
    sum_t red;
    sum_t green;
    sum_t blue;
  } rgb_sum_t;

endpackage

`default_nettype wire

// File: design/acdm_in_if.sv
// Input channel of the color distance mask: valid/ready plus one pixel item.
// Depends on acdm_pkg.
`default_nettype none

interface acdm_in_if;
  import acdm_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] operation;
  chan_t      red;
  chan_t      green;
  chan_t      blue;

  modport source(output valid, operation, red, green, blue, input ready);
  modport sink(input valid, operation, red, green, blue, output ready);
endinterface

`default_nettype wire

// File: design/acdm_out_if.sv
// Result channel of the color distance mask: valid/ready plus one result item.
// Depends on acdm_pkg.
`default_nettype none

interface acdm_out_if;
  import acdm_pkg::*;

  logic   valid;
  logic   ready;
  logic   result_kind;
  logic   mask;
  count_t accepted_count;
  cut_t   cut_distance;

  modport source(output valid, result_kind, mask, accepted_count, cut_distance, input ready);
  modport sink(input valid, result_kind, mask, accepted_count, cut_distance, output ready);
endinterface

`default_nettype wire

// File: design/acdm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module acdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/acdm_dist.sv
// Color distance unit: floor(sqrt(dr^2+dg^2+db^2)), combinational squares,
// then a bit-pair root iteration one step per cycle. Depends on acdm_pkg.
`default_nettype none

module acdm_dist (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  acdm_pkg::rgb_t pix,
  input  acdm_pkg::rgb_t target,
  output logic          done,
  output acdm_pkg::cut_t distance
);
  import acdm_pkg::*;

  chan_t               dr, dg, db;
  logic [2*CHAN_W-1:0] sq_r, sq_g, sq_b;
  logic [SQ_W-1:0]     sq_sum;
  logic                sq_pend;
  logic                rt_busy;
  logic [SQ_W-1:0]     rem, rem_next;
  logic [SQ_W-1:0]     root, root_next;
  logic [SQ_W-2:0]     probe;
  logic [SQ_W:0]       trial;

  assign sq_r   = dr * dr;
  assign sq_g   = dg * dg;
  assign sq_b   = db * db;
  assign sq_sum = SQ_W'(sq_r) + SQ_W'(sq_g) + SQ_W'(sq_b);

  always_comb begin
    trial = {1'b0, root} + (SQ_W + 1)'(probe);
    if ({1'b0, rem} >= trial) begin
      rem_next  = SQ_W'({1'b0, rem} - trial);
      root_next = (root >> 1) + SQ_W'(probe);
    end else begin
      rem_next  = rem;
      root_next = root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_pend <= 1'b0;
      rt_busy <= 1'b0;
      done    <= 1'b0;
    end else begin
      sq_pend <= start;
      done    <= rt_busy && !sq_pend && probe == (SQ_W - 1)'(1);
      if (sq_pend) begin
        rt_busy <= 1'b1;
      end else if (rt_busy && probe == (SQ_W - 1)'(1)) begin
        rt_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dr <= (pix.red > target.red) ? pix.red - target.red : target.red - pix.red;
      dg <= (pix.green > target.green) ? pix.green - target.green
                                       : target.green - pix.green;
      db <= (pix.blue > target.blue) ? pix.blue - target.blue : target.blue - pix.blue;
    end
    if (sq_pend) begin
      rem   <= sq_sum;
      root  <= '0;
      probe <= {1'b1, {(SQ_W - 2){1'b0}}};
    end else if (rt_busy) begin
      rem   <= rem_next;
      root  <= root_next;
      probe <= probe >> 2;
      if (probe == (SQ_W - 1)'(1)) begin
        distance <= CUT_W'(root_next);
      end
    end
  end

endmodule

`default_nettype wire

// File: design/acdm_div.sv
// Mean color divider: three channel sums over one pixel count, restoring
// division one quotient bit per cycle in three lanes. Depends on acdm_pkg.
`default_nettype none

module acdm_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  acdm_pkg::rgb_sum_t sums,
  input  acdm_pkg::count_t  total,
  output logic              done,
  output acdm_pkg::rgb_t    mean
);
  import acdm_pkg::*;

  // each sum is below 256 * total, so eight quotient bits suffice
  sum_t               rem [3];
  chan_t              quo [3];
  sum_t               den;
  logic [QSTEP_W-1:0] step;
  logic               busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && step == QSTEP_W'(CHAN_W - 1);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + QSTEP_W'(1);
        if (step == QSTEP_W'(CHAN_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem[0] <= sums.red;
      rem[1] <= sums.green;
      rem[2] <= sums.blue;
      for (int k = 0; k < 3; k++) begin
        quo[k] <= '0;
      end
      den <= {total, {(CHAN_W - 1){1'b0}}};
    end else if (busy) begin
      for (int k = 0; k < 3; k++) begin
        if (rem[k] >= den) begin
          rem[k] <= rem[k] - den;
          quo[k] <= {quo[k][CHAN_W-2:0], 1'b1};
        end else begin
          quo[k] <= {quo[k][CHAN_W-2:0], 1'b0};
        end
      end
      den <= den >> 1;
    end
  end

  assign mean.red   = quo[0];
  assign mean.green = quo[1];
  assign mean.blue  = quo[2];

endmodule

`default_nettype wire

// File: design/adaptive_color_distance_mask.sv
// Top level of the adaptive color distance mask: control sequencer, frame
// registers, histogram RAM. Depends on acdm_pkg, acdm_in_if, acdm_out_if,
// acdm_ram, acdm_dist and acdm_div.
//
//   channel   kind          direction  carries
//   -------   -----------   ---------  ---------------------------------------------
//   pixel     valid/ready   in         operation, red, green, blue
//   result    valid/ready   out        result_kind, mask, accepted_count, cut_distance
//   write_*   write strobe  in         write_index, write_data (no read-back)
//
// One item is in flight at a time; the distance root unit (one bit pair per
// cycle) sets the pace. Finish runs the divider, the root and a bin walk
// through the RAM read port (read issued in ST_WALK_A, bin folded in ST_WALK_B),
// then a 444-entry histogram clearing sweep.
// Reset is synchronous; after it the same clearing sweep runs with ready low.
// A result waits in the output register; only a new result stalls on it.
`default_nettype none

module adaptive_color_distance_mask (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             write_enable,
  input  logic [acdm_pkg::REG_IDX_W-1:0]   write_index,
  input  logic [acdm_pkg::CFG_W-1:0]       write_data,
  acdm_in_if.sink                          pixel,
  acdm_out_if.source                       result
);
  import acdm_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DIST   = 4'd1;  // pixel distance in progress
  localparam logic [3:0] ST_POST   = 4'd2;  // histogram read or mask out
  localparam logic [3:0] ST_ACC_WR = 4'd3;  // histogram write-back
  localparam logic [3:0] ST_DIV    = 4'd4;  // mean color
  localparam logic [3:0] ST_MDIST  = 4'd5;  // mean color distance
  localparam logic [3:0] ST_WALK_A = 4'd6;  // test stop rule, issue bin read
  localparam logic [3:0] ST_WALK_B = 4'd7;  // fold bin into walk state
  localparam logic [3:0] ST_REPORT = 4'd8;
  localparam logic [3:0] ST_CLEAR  = 4'd9;

  logic [3:0] state;

  // configuration
  rgb_t               target;
  count_t             min_pixels;
  cut_t               max_distance;
  logic [RATIO_W-1:0] precision_ratio;
  logic [RATIO_W-1:0] ratio_eff;

  // frame state
  rgb_sum_t sums;
  count_t   pixel_total;
  cut_t     current_cut;

  // current item
  logic [1:0] op_q;
  rgb_t       pix_q;
  rgb_t       pix_in;

  // cut walk: lhs = (i - s) * ratio, rhs = (avg - s) * 256, s = -1 until set
  cut_t             walk_i;
  cut_t             avg;
  logic             s_valid;
  count_t           blob;
  logic [LHS_W-1:0] lhs;
  logic [RHS_W-1:0] rhs;
  logic             rhs_neg;
  logic             walk_go;
  logic             walk_in_range;
  count_t           bin_cnt;
  logic [COUNT_W:0] blob_sum;
  count_t           blob_sat;

  logic [BIN_AW-1:0] clr_addr;

  // units
  logic     accept;
  logic     out_free;
  logic     res_load;
  logic     dist_start, dist_done;
  rgb_t     dist_src;
  cut_t     pix_dist;
  logic     dist_in_range;
  logic     div_start, div_done;
  rgb_t     div_mean;
  rgb_t     mean_eff;

  logic              ram_we;
  logic [BIN_AW-1:0] ram_waddr, ram_raddr;
  count_t            ram_wdata, ram_rdata;

  assign pixel.ready = (state == ST_IDLE);
  assign accept      = pixel.valid && pixel.ready;
  assign out_free    = !result.valid || result.ready;
  // a mask or a frame report goes into the output register this cycle
  assign res_load    = out_free
                       && ((state == ST_POST && op_q != OP_ACCUMULATE) || state == ST_REPORT);

  assign pix_in.red   = pixel.red;
  assign pix_in.green = pixel.green;
  assign pix_in.blue  = pixel.blue;

  assign ratio_eff = (precision_ratio == '0) ? RATIO_W'(1) : precision_ratio;
  assign mean_eff  = (pixel_total == '0) ? '0 : div_mean;

  assign dist_in_range = {1'b0, pix_dist} < (CUT_W + 1)'(DISTANCE_BINS);
  assign walk_in_range = {1'b0, walk_i} < (CUT_W + 1)'(DISTANCE_BINS);

  // ---------------------------------------------------------------------------
  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target          <= '0;
      min_pixels      <= '0;
      max_distance    <= MAX_DIST_RESET;
      precision_ratio <= RATIO_RESET;
    end else if (write_enable) begin
      case (write_index)
        REG_TARGET_RED:      target.red      <= write_data[CHAN_W-1:0];
        REG_TARGET_GREEN:    target.green    <= write_data[CHAN_W-1:0];
        REG_TARGET_BLUE:     target.blue     <= write_data[CHAN_W-1:0];
        REG_MIN_PIXELS:      min_pixels      <= write_data[COUNT_W-1:0];
        REG_MAX_DISTANCE:    max_distance    <= write_data[CUT_W-1:0];
        REG_PRECISION_RATIO: precision_ratio <= write_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // unit starts and RAM port steering
  always_comb begin
    dist_src   = (state == ST_DIV) ? mean_eff : pix_in;
    dist_start = (accept && ((pixel.operation == OP_ACCUMULATE && pixel_total < PIX_LIMIT)
                             || pixel.operation == OP_CLASSIFY))
                 || (state == ST_DIV && div_done);
    div_start  = accept && pixel.operation == OP_FINISH;

    ram_raddr = '0;
    case (state)
      ST_POST:   if (dist_in_range) ram_raddr = pix_dist[BIN_AW-1:0];
      ST_WALK_A: if (walk_in_range) ram_raddr = walk_i[BIN_AW-1:0];
      default: ;
    endcase

    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    if (state == ST_ACC_WR && dist_in_range) begin
      // read in ST_POST, one item at a time, so no overlap on an entry
      ram_we    = 1'b1;
      ram_waddr = pix_dist[BIN_AW-1:0];
      ram_wdata = ram_rdata + COUNT_W'(1);
    end else if (state == ST_CLEAR) begin
      ram_we = 1'b1;
    end
  end

  // walk step logic
  always_comb begin
    walk_go  = (walk_i < max_distance)
               && ((blob < min_pixels) || (!rhs_neg && lhs < LHS_W'(rhs)));
    bin_cnt  = walk_in_range ? ram_rdata : '0;
    blob_sum = {1'b0, blob} + {1'b0, bin_cnt};
    blob_sat = (blob_sum > {1'b0, PIX_LIMIT}) ? PIX_LIMIT : blob_sum[COUNT_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      result.valid <= 1'b0;
      sums         <= '0;
      pixel_total  <= '0;
      current_cut  <= '0;
    end else begin
      if (res_load) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op_q  <= pixel.operation;
            pix_q <= pix_in;
            case (pixel.operation)
              OP_ACCUMULATE: if (pixel_total < PIX_LIMIT) state <= ST_DIST;
              OP_FINISH:     state <= ST_DIV;
              OP_CLASSIFY:   state <= ST_DIST;
              default: ;
            endcase
          end
        end
        ST_DIST: begin
          if (dist_done) state <= ST_POST;
        end
        ST_POST: begin
          if (op_q == OP_ACCUMULATE) begin
            state <= ST_ACC_WR;
          end else if (out_free) begin
            result.result_kind    <= KIND_MASK;
            result.mask           <= (pix_dist < current_cut);
            result.accepted_count <= '0;
            result.cut_distance   <= '0;
            state                 <= ST_IDLE;
          end
        end
        ST_ACC_WR: begin
          sums.red    <= sums.red + SUM_W'(pix_q.red);
          sums.green  <= sums.green + SUM_W'(pix_q.green);
          sums.blue   <= sums.blue + SUM_W'(pix_q.blue);
          pixel_total <= pixel_total + COUNT_W'(1);
          state       <= ST_IDLE;
        end
        ST_DIV: begin
          if (div_done) state <= ST_MDIST;
        end
        ST_MDIST: begin
          if (dist_done) begin
            avg     <= pix_dist;
            walk_i  <= '0;
            s_valid <= 1'b0;
            blob    <= '0;
            lhs     <= LHS_W'(ratio_eff);
            rhs     <= {({1'b0, pix_dist} + (CUT_W + 1)'(1)), 8'b0};
            rhs_neg <= 1'b0;
            state   <= ST_WALK_A;
          end
        end
        ST_WALK_A: begin
          state <= walk_go ? ST_WALK_B : ST_REPORT;
        end
        ST_WALK_B: begin
          if (bin_cnt != '0 && !s_valid) begin
            // first nonempty bin: s = i, next i - s is one
            s_valid <= 1'b1;
            lhs     <= LHS_W'(ratio_eff);
            if (avg >= walk_i) begin
              rhs     <= {1'b0, avg - walk_i, 8'b0};
              rhs_neg <= 1'b0;
            end else begin
              rhs_neg <= 1'b1;
            end
          end else begin
            lhs <= lhs + LHS_W'(ratio_eff);
          end
          blob   <= blob_sat;
          walk_i <= walk_i + CUT_W'(1);
          state  <= ST_WALK_A;
        end
        ST_REPORT: begin
          if (out_free) begin
            result.result_kind    <= KIND_REPORT;
            result.mask           <= 1'b0;
            result.accepted_count <= blob;
            result.cut_distance   <= walk_i;
            current_cut           <= walk_i;
            sums                  <= '0;
            pixel_total           <= '0;
            clr_addr              <= '0;
            state                 <= ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + BIN_AW'(1);
          if (clr_addr == BIN_AW'(DISTANCE_BINS - 1)) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  acdm_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(DISTANCE_BINS)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  acdm_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .start   (dist_start),
    .pix     (dist_src),
    .target  (target),
    .done    (dist_done),
    .distance(pix_dist)
  );

  acdm_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .sums (sums),
    .total(pixel_total),
    .done (div_done),
    .mean (div_mean)
  );

`ifndef ASSERT_OFF
  a_total_bounded: assert property (@(posedge clk) disable iff (rst)
    pixel_total <= PIX_LIMIT)
    else $error("pixel count above limit");

  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK_B) |-> (walk_i < max_distance))
    else $error("bin walk past max distance");

  a_blob_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK_A || state == ST_REPORT) |-> (blob <= PIX_LIMIT))
    else $error("accepted count not saturated");

  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPORT && out_free) |=>
      (state == ST_CLEAR && pixel_total == '0 && clr_addr == '0))
    else $error("frame not cleared after report");

  a_acc_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC_WR && ram_we) |-> (ram_wdata != '0))
    else $error("histogram increment wrapped");
`endif

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Testbench for adaptive_color_distance_mask: a predictor class tracks the
// histogram, sums and cut and checks every result. Needs acdm_pkg, acdm_in_if,
// acdm_out_if and the block itself.
`timescale 1ns / 1ps

module testbench;
  import acdm_pkg::*;

  // no package name exists for the spare operation code
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int CLEAR_WAIT   = 600;    // root + walk tail + 444-entry clearing sweep
  localparam int STALL_LIMIT  = 20000;  // cycles without any transaction
  localparam int RANDOM_ITEMS = 1600;

  typedef logic [RATIO_W-1:0] ratio_t;

  typedef struct packed {
    logic   kind;
    logic   mask;
    count_t count;
    cut_t   cut;
  } outcome_t;

  // Predicts frame reports and pixel masks; holds the outcomes still owed.
  class cut_and_mask_model;
    chan_t       tgt_r, tgt_g, tgt_b;
    count_t      min_pix;
    cut_t        max_dist;
    ratio_t      ratio;
    count_t      hist[DISTANCE_BINS];
    int unsigned sum_r, sum_g, sum_b, total;
    cut_t        cut;
    outcome_t    outcomes_due[$];
    int unsigned mismatches;

    function new();
      tgt_r      = '0;
      tgt_g      = '0;
      tgt_b      = '0;
      min_pix    = '0;
      max_dist   = MAX_DIST_RESET;
      ratio      = RATIO_RESET;
      cut        = '0;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      foreach (hist[k]) hist[k] = '0;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      total = 0;
    endfunction

    // floor of the square root, one result bit at a time (root < 512)
    function int unsigned floor_root(int unsigned n);
      int unsigned r;
      r = 0;
      for (int b = 8; b >= 0; b--) begin
        if (((r | (1 << b)) * (r | (1 << b))) <= n) r = r | (1 << b);
      end
      return r;
    endfunction

    function int unsigned distance_to_target(chan_t r, chan_t g, chan_t b);
      int dr, dg, db;
      dr = int'(tgt_r) - int'(r);
      dg = int'(tgt_g) - int'(g);
      db = int'(tgt_b) - int'(b);
      return floor_root(dr * dr + dg * dg + db * db);
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_TARGET_RED:      tgt_r = data[CHAN_W-1:0];
        REG_TARGET_GREEN:    tgt_g = data[CHAN_W-1:0];
        REG_TARGET_BLUE:     tgt_b = data[CHAN_W-1:0];
        REG_MIN_PIXELS:      min_pix = data[COUNT_W-1:0];
        REG_MAX_DISTANCE:    max_dist = data[CUT_W-1:0];
        REG_PRECISION_RATIO: ratio = data[RATIO_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_item(logic [1:0] op, chan_t r, chan_t g, chan_t b);
      int unsigned d, blob, cnt;
      chan_t       mr, mg, mb;
      longint      avg, s, i, rat;
      outcome_t    o;
      case (op)
        OP_ACCUMULATE: begin
          // a full frame drops further pixels entirely
          if (total < PIX_LIMIT) begin
            d = distance_to_target(r, g, b);
            if (d < DISTANCE_BINS) hist[d] = hist[d] + 1'b1;
            sum_r += 32'(r);
            sum_g += 32'(g);
            sum_b += 32'(b);
            total++;
          end
        end
        OP_FINISH: begin
          mr = '0;
          mg = '0;
          mb = '0;
          if (total != 0) begin
            mr = chan_t'(sum_r / total);
            mg = chan_t'(sum_g / total);
            mb = chan_t'(sum_b / total);
          end
          avg  = distance_to_target(mr, mg, mb);
          rat  = (ratio == 0) ? 1 : longint'(ratio);
          s    = -1;
          i    = 0;
          blob = 0;
          while (i < max_dist && (blob < min_pix || (i - s) * rat < (avg - s) * 256)) begin
            cnt = (i < DISTANCE_BINS) ? 32'(hist[i]) : 0;
            if (cnt != 0 && s < 0) s = i;
            blob += cnt;
            if (blob > PIX_LIMIT) blob = 32'(PIX_LIMIT);
            i++;
          end
          cut     = i[CUT_W-1:0];
          o.kind  = KIND_REPORT;
          o.mask  = 1'b0;
          o.count = blob[COUNT_W-1:0];
          o.cut   = cut;
          outcomes_due.push_back(o);
          clear_frame();
        end
        OP_CLASSIFY: begin
          d       = distance_to_target(r, g, b);
          o.kind  = KIND_MASK;
          o.mask  = (d < cut);
          o.count = '0;
          o.cut   = '0;
          outcomes_due.push_back(o);
        end
        default: ;
      endcase
    endfunction

    function void check_outcome(logic kind, logic mask, count_t count, cut_t cut_d);
      outcome_t e;
      if (outcomes_due.size() == 0) begin
        $error("unexpected result: kind %0d mask %0d count %0d cut %0d",
               kind, mask, count, cut_d);
        mismatches++;
        return;
      end
      e = outcomes_due.pop_front();
      if (kind !== e.kind) begin
        $error("result_kind: expected %0d, actual %0d", e.kind, kind);
        mismatches++;
      end
      if (mask !== e.mask) begin
        $error("mask: expected %0d, actual %0d", e.mask, mask);
        mismatches++;
      end
      if (count !== e.count) begin
        $error("accepted_count: expected %0d, actual %0d", e.count, count);
        mismatches++;
      end
      if (cut_d !== e.cut) begin
        $error("cut_distance: expected %0d, actual %0d", e.cut, cut_d);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 write_enable;
  logic [REG_IDX_W-1:0] write_index;
  logic [CFG_W-1:0]     write_data;
  bit                   steady;        // disables idling on both sides
  int                   stall_cycles;

  cut_and_mask_model model = new();

  acdm_in_if  pixel_ch();
  acdm_out_if result_ch();

  adaptive_color_distance_mask DUT (
    .clk         (clk),
    .rst         (rst),
    .write_enable(write_enable),
    .write_index (write_index),
    .write_data  (write_data),
    .pixel       (pixel_ch),
    .result      (result_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each transaction, then stall at random for the next edge.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready)
        model.check_outcome(result_ch.result_kind, result_ch.mask,
                            result_ch.accepted_count, result_ch.cut_distance);
      result_ch.ready <= steady || ($urandom_range(99) >= 31);
    end
  end

  // Watchdog: any transaction on either channel counts as progress.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // One pixel-channel transaction, with random idle cycles ahead of it.
  // valid stays high on return so back-to-back items need no extra edge.
  task automatic send_item(logic [1:0] op, chan_t r, chan_t g, chan_t b);
    while (!steady && $urandom_range(99) < 31) begin
      pixel_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_ch.valid     <= 1'b1;
    pixel_ch.operation <= op;
    pixel_ch.red       <= r;
    pixel_ch.green     <= g;
    pixel_ch.blue      <= b;
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
    model.take_item(op, r, g, b);
  endtask

  // Stop sending and let the block go quiet: all results in, clearing sweep done.
  task automatic drain();
    pixel_ch.valid <= 1'b0;
    while (model.outcomes_due.size() != 0) @(posedge clk);
    repeat (CLEAR_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= data;
    @(posedge clk);
    model.write_reg(idx, data);
  endtask

  // Registers change only with the block idle.
  task automatic write_settings(chan_t tr, chan_t tg, chan_t tb, count_t minp,
                                cut_t maxd, ratio_t rat);
    drain();
    write_reg(REG_TARGET_RED, CFG_W'(tr));
    write_reg(REG_TARGET_GREEN, CFG_W'(tg));
    write_reg(REG_TARGET_BLUE, CFG_W'(tb));
    write_reg(REG_MIN_PIXELS, CFG_W'(minp));
    write_reg(REG_MAX_DISTANCE, CFG_W'(maxd));
    write_reg(REG_PRECISION_RATIO, CFG_W'(rat));
    write_enable <= 1'b0;
  endtask

  // target channel: extremes a quarter of the time
  function automatic chan_t pick_channel();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'd255 : 8'd0;
    return chan_t'($urandom_range(255));
  endfunction

  function automatic chan_t jitter(chan_t c, int spread);
    int v;
    v = int'(c) + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return chan_t'(v);
  endfunction

  task automatic random_settings();
    count_t minp;
    cut_t   maxd;
    ratio_t rat;
    case ($urandom_range(5))
      0:       minp = '0;
      1:       minp = PIX_LIMIT;
      default: minp = count_t'($urandom_range(120));
    endcase
    case ($urandom_range(5))
      0:       maxd = '0;
      1:       maxd = cut_t'($urandom_range(511));
      default: maxd = MAX_DIST_RESET;
    endcase
    case ($urandom_range(5))
      0:       rat = '0;
      1:       rat = 16'd1;
      2:       rat = 16'hffff;
      3:       rat = RATIO_RESET;
      default: rat = ratio_t'($urandom_range(16'hffff, 1));
    endcase
    write_settings(pick_channel(), pick_channel(), pick_channel(), minp, maxd, rat);
  endtask

  // Pixel drawn mostly around a frame's center color, otherwise uniform.
  task automatic send_pixel(logic [1:0] op, chan_t cr, chan_t cg, chan_t cb, int spread);
    if ($urandom_range(99) < 60)
      send_item(op, jitter(cr, spread), jitter(cg, spread), jitter(cb, spread));
    else
      send_item(op, chan_t'($urandom_range(255)), chan_t'($urandom_range(255)),
                chan_t'($urandom_range(255)));
  endtask

  initial begin
    int    n_items;
    int    n_acc;
    int    n_cls;
    int    spread;
    chan_t cr, cg, cb;

    rst                = 1'b1;
    steady             = 1'b0;
    write_enable       = 1'b0;
    write_index        = '0;
    write_data         = '0;
    pixel_ch.valid     = 1'b0;
    pixel_ch.operation = OP_ACCUMULATE;
    pixel_ch.red       = '0;
    pixel_ch.green     = '0;
    pixel_ch.blue      = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: empty finish, classify at cut 0, spare opcode, then a frame
    send_item(OP_FINISH, 8'd0, 8'd0, 8'd0);
    send_item(OP_CLASSIFY, 8'd0, 8'd0, 8'd0);
    send_item(OP_UNUSED, 8'd255, 8'd255, 8'd255);
    send_item(OP_ACCUMULATE, 8'd0, 8'd0, 8'd0);
    send_item(OP_ACCUMULATE, 8'd255, 8'd255, 8'd255);
    send_item(OP_ACCUMULATE, 8'd255, 8'd0, 8'd0);
    send_item(OP_ACCUMULATE, 8'd0, 8'd255, 8'd0);
    send_item(OP_ACCUMULATE, 8'd0, 8'd0, 8'd255);
    send_item(OP_ACCUMULATE, 8'd128, 8'd128, 8'd128);
    send_item(OP_FINISH, 8'd255, 8'd255, 8'd255);
    send_item(OP_CLASSIFY, 8'd0, 8'd0, 8'd0);
    send_item(OP_CLASSIFY, 8'd255, 8'd255, 8'd255);
    send_item(OP_CLASSIFY, 8'd10, 8'd10, 8'd10);

    // zero precision ratio acts as one
    write_settings(8'd255, 8'd255, 8'd255, '0, MAX_DIST_RESET, '0);
    send_item(OP_ACCUMULATE, 8'd250, 8'd250, 8'd250);
    send_item(OP_ACCUMULATE, 8'd200, 8'd255, 8'd240);
    send_item(OP_ACCUMULATE, 8'd0, 8'd0, 8'd0);
    send_item(OP_FINISH, 8'd0, 8'd0, 8'd0);
    send_item(OP_CLASSIFY, 8'd255, 8'd255, 8'd255);
    send_item(OP_CLASSIFY, 8'd0, 8'd0, 8'd0);

    // huge minimum blob: the walk runs past the last bin up to 511
    write_settings(8'd0, 8'd0, 8'd0, PIX_LIMIT, 9'd511, 16'hffff);
    send_item(OP_ACCUMULATE, 8'd255, 8'd255, 8'd255);
    send_item(OP_FINISH, 8'd0, 8'd0, 8'd0);
    send_item(OP_CLASSIFY, 8'd255, 8'd255, 8'd255);

    // zero distance limit: cut stays at zero
    write_settings(8'd0, 8'd0, 8'd0, '0, '0, 16'd1);
    send_item(OP_ACCUMULATE, 8'd1, 8'd1, 8'd1);
    send_item(OP_FINISH, 8'd0, 8'd0, 8'd0);

    // Random frames: accumulate a cluster plus noise, finish, then classify.
    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      steady = (n_items >= 600 && n_items < 900);
      if ($urandom_range(99) < 35) random_settings();
      else if ($urandom_range(99) < 10) drain();

      if ($urandom_range(1)) begin
        cr = jitter(model.tgt_r, 40);
        cg = jitter(model.tgt_g, 40);
        cb = jitter(model.tgt_b, 40);
      end else begin
        cr = chan_t'($urandom_range(255));
        cg = chan_t'($urandom_range(255));
        cb = chan_t'($urandom_range(255));
      end
      spread = $urandom_range(30);
      n_acc  = ($urandom_range(9) == 0) ? $urandom_range(250, 120) : $urandom_range(60);

      for (int k = 0; k < n_acc; k++) begin
        if ($urandom_range(99) < 5)
          send_item(OP_UNUSED, chan_t'($urandom_range(255)), chan_t'($urandom_range(255)),
                    chan_t'($urandom_range(255)));
        send_pixel(OP_ACCUMULATE, cr, cg, cb, spread);
        n_items++;
      end
      // broken sequence: a classify inside the frame
      if ($urandom_range(99) < 8) begin
        send_pixel(OP_CLASSIFY, cr, cg, cb, spread);
        n_items++;
      end
      send_item(OP_FINISH, chan_t'($urandom_range(255)), chan_t'($urandom_range(255)),
                chan_t'($urandom_range(255)));
      n_items++;
      // a second finish reports an empty frame
      if ($urandom_range(99) < 10) begin
        send_item(OP_FINISH, 8'd0, 8'd0, 8'd0);
        n_items++;
      end
      n_cls = $urandom_range(25, 1);
      for (int k = 0; k < n_cls; k++) begin
        send_pixel(OP_CLASSIFY, cr, cg, cb, spread + 20);
        n_items++;
      end
    end
    steady = 1'b0;

    drain();
    if (model.mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
design/acdm_pkg.sv
design/acdm_in_if.sv
design/acdm_out_if.sv
design/acdm_ram.sv
design/acdm_dist.sv
design/acdm_div.sv
design/adaptive_color_distance_mask.sv
dv/testbench.sv
